/* rtl/sbat_pkg.sv */
`timescale 1ns / 1ps

package sbat_pkg;

    localparam int MAX_SPRITES_DEF  = 64;
    localparam int VERTS_PER_SPRITE = 6;

    localparam int TEX_W    = 32;
    localparam int DEPTH_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int VERT_W   = 9;

    typedef enum logic [1:0] {
        MODE_DEPTH_DESC = 2'd0,
        MODE_DEPTH_ASC  = 2'd1,
        MODE_TEX_ASC    = 2'd2,
        MODE_LOAD_ORDER = 2'd3
    } t_sort_mode;

    typedef struct packed {
        logic less;
        logic equal;
    } t_cmp_res;

endpackage

/* rtl/sbat_ram.sv */
`timescale 1ns / 1ps

module sbat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sbat_cmp.sv */
`timescale 1ns / 1ps

module sbat_cmp
    import sbat_pkg::*;
(
    input  t_sort_mode                 i_mode,
    input  logic [TEX_W-1:0]           i_tex_a,
    input  logic signed [DEPTH_W-1:0]  i_dep_a,
    input  logic [TEX_W-1:0]           i_tex_b,
    input  logic signed [DEPTH_W-1:0]  i_dep_b,
    output t_cmp_res                   o_res
);

    logic signed [TEX_W:0] key_a;
    logic signed [TEX_W:0] key_b;

    // a goes strictly before b when key_a < key_b
    always_comb begin
        key_a = '0;
        key_b = '0;
        o_res = '{less: 1'b0, equal: 1'b1};
        unique case (i_mode)
            MODE_DEPTH_DESC: begin
                key_a = -((TEX_W+1)'(i_dep_a));
                key_b = -((TEX_W+1)'(i_dep_b));
                o_res = '{less: key_a < key_b, equal: key_a == key_b};
            end
            MODE_DEPTH_ASC: begin
                key_a = (TEX_W+1)'(i_dep_a);
                key_b = (TEX_W+1)'(i_dep_b);
                o_res = '{less: key_a < key_b, equal: key_a == key_b};
            end
            MODE_TEX_ASC: begin
                key_a = $signed({1'b0, i_tex_a});
                key_b = $signed({1'b0, i_tex_b});
                o_res = '{less: key_a < key_b, equal: key_a == key_b};
            end
            MODE_LOAD_ORDER: begin
                o_res = '{less: 1'b0, equal: 1'b1};
            end
        endcase
    end

endmodule

/* rtl/sprite_sort_and_batch.sv */
`timescale 1ns / 1ps

// Sprite sorter with draw batching. Every input beat loads one sprite while the block is
// idle; loads past MAX_SPRITES are dropped and flagged. A beat marked final starts a
// stable rank sort of the n loaded sprites under the sort_mode register: one comparator
// and one read port of the record stores check each sprite against every other, then a
// backward pass over the sorted order measures texture runs, and the emit reads the
// order, texture and run length of each result beat and holds it until it is taken.
// The block takes no input beat from the final beat until the last result beat has been
// taken. sort_mode must be written only while idle; the block itself does not enforce it.
module sprite_sort_and_batch
    import sbat_pkg::*;
#(
    parameter int MAX_SPRITES = MAX_SPRITES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [TEX_W-1:0]          i_texture_id,
    input  logic signed [DEPTH_W-1:0] i_depth_key,
    input  logic                      i_final_sprite,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [INDEX_W-1:0]        o_sprite_index,
    output logic [TEX_W-1:0]          o_sprite_texture,
    output logic [VERT_W-1:0]         o_vertex_offset,
    output logic                      o_starts_batch,
    output logic [VERT_W-1:0]         o_batch_vertices,
    output logic                      o_overflowed,
    output logic                      o_end_of_list
);

    localparam int IW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RI, S_KI, S_CJ, S_WR, S_BO, S_BT, S_BR, S_EO, S_ET, S_EC, S_EW
    } t_state;

    t_state              r_state;
    t_sort_mode          r_mode;
    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [IW-1:0]       r_last;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_j;
    logic [IW-1:0]       r_k;
    logic [IW-1:0]       r_rank;
    logic [TEX_W-1:0]    r_ti;
    logic [DEPTH_W-1:0]  r_di;
    logic [TEX_W-1:0]    r_tnext;
    logic [CW-1:0]       r_run;
    logic [VERT_W-1:0]   r_off;

    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_sprite_index;
    logic [TEX_W-1:0]    r_sprite_texture;
    logic [VERT_W-1:0]   r_vertex_offset;
    logic                r_starts_batch;
    logic [VERT_W-1:0]   r_batch_vertices;
    logic                r_overflowed;
    logic                r_end_of_list;

    logic                full;
    logic                load_we;
    logic [IW-1:0]       store_raddr;
    logic [TEX_W-1:0]    tex_rdata;
    logic [DEPTH_W-1:0]  dep_rdata;
    logic                ord_we;
    logic [IW-1:0]       ord_rdata;
    logic                run_we;
    logic [CW-1:0]       run_rdata;
    logic [CW-1:0]       n_run;
    logic [IW-1:0]       n_rank;
    t_cmp_res            cmp_res;
    logic                rank_inc;
    logic                e_starts;
    logic [VERT_W-1:0]   e_batch;

    assign full    = (r_count == CW'(MAX_SPRITES));
    assign load_we = (r_state == S_IDLE) && i_in_valid && !full;
    assign ord_we  = (r_state == S_WR);
    assign run_we  = (r_state == S_BR);

    always_comb begin
        unique case (r_state)
            S_RI:        store_raddr = r_i;
            S_KI:        store_raddr = r_j;
            S_CJ:        store_raddr = r_j + 1'b1;
            S_BT, S_ET:  store_raddr = ord_rdata;
            default:     store_raddr = r_i;
        endcase
    end

    sbat_ram #(.WIDTH(TEX_W), .DEPTH(MAX_SPRITES)) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (i_texture_id),
        .i_raddr (store_raddr),
        .o_rdata (tex_rdata)
    );

    sbat_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_SPRITES)) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (i_depth_key),
        .i_raddr (store_raddr),
        .o_rdata (dep_rdata)
    );

    sbat_ram #(.WIDTH(IW), .DEPTH(MAX_SPRITES)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (r_rank),
        .i_wdata (r_i),
        .i_raddr (r_k),
        .o_rdata (ord_rdata)
    );

    sbat_ram #(.WIDTH(CW), .DEPTH(MAX_SPRITES)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (r_k),
        .i_wdata (n_run),
        .i_raddr (r_k),
        .o_rdata (run_rdata)
    );

    // sprite j against sprite i
    sbat_cmp u_cmp (
        .i_mode  (r_mode),
        .i_tex_a (tex_rdata),
        .i_dep_a ($signed(dep_rdata)),
        .i_tex_b (r_ti),
        .i_dep_b ($signed(r_di)),
        .o_res   (cmp_res)
    );

    // ties go to the earlier load
    assign rank_inc = cmp_res.less || (cmp_res.equal && (r_j < r_i));
    assign n_rank   = r_rank + IW'(rank_inc);

    assign n_run = ((r_k == r_last) || (tex_rdata != r_tnext)) ? CW'(1) : r_run + 1'b1;

    assign e_starts = (r_k == '0) || (tex_rdata != r_tnext);
    assign e_batch  = e_starts ? VERT_W'(run_rdata * VERTS_PER_SPRITE) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_TEX_ASC;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_sort_mode'(i_cfg_wdata);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (!full) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_final_sprite) begin
                            r_last  <= full ? IW'(r_count - 1'b1) : IW'(r_count);
                            r_i     <= '0;
                            r_state <= S_RI;
                        end
                    end
                end
                S_RI: begin
                    r_j     <= '0;
                    r_rank  <= '0;
                    r_state <= S_KI;
                end
                S_KI: begin
                    r_ti    <= tex_rdata;
                    r_di    <= dep_rdata;
                    r_state <= S_CJ;
                end
                S_CJ: begin
                    r_rank <= n_rank;
                    r_j    <= r_j + 1'b1;
                    if (r_j == r_last) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_i == r_last) begin
                        r_k     <= r_last;
                        r_state <= S_BO;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RI;
                    end
                end
                S_BO: r_state <= S_BT;
                S_BT: r_state <= S_BR;
                S_BR: begin
                    r_run   <= n_run;
                    r_tnext <= tex_rdata;
                    if (r_k == '0) begin
                        r_off   <= '0;
                        r_state <= S_EO;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_BO;
                    end
                end
                S_EO: r_state <= S_ET;
                S_ET: r_state <= S_EC;
                S_EC: begin
                    r_out_valid      <= 1'b1;
                    r_sprite_index   <= INDEX_W'(ord_rdata);
                    r_sprite_texture <= tex_rdata;
                    r_vertex_offset  <= r_off;
                    r_starts_batch   <= e_starts;
                    r_batch_vertices <= e_batch;
                    r_overflowed     <= r_ovf;
                    r_end_of_list    <= (r_k == r_last);
                    r_tnext          <= tex_rdata;
                    r_state          <= S_EW;
                end
                S_EW: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_end_of_list) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_off   <= r_off + VERT_W'(VERTS_PER_SPRITE);
                            r_state <= S_EO;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_sprite_index   = r_sprite_index;
    assign o_sprite_texture = r_sprite_texture;
    assign o_vertex_offset  = r_vertex_offset;
    assign o_starts_batch   = r_starts_batch;
    assign o_batch_vertices = r_batch_vertices;
    assign o_overflowed     = r_overflowed;
    assign o_end_of_list    = r_end_of_list;

endmodule

/* rtl/sbat_chk.sv */
`timescale 1ns / 1ps

module sbat_chk
    import sbat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_in_ready,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic [INDEX_W-1:0] o_sprite_index,
    input  logic [VERT_W-1:0]  o_vertex_offset,
    input  logic               o_starts_batch,
    input  logic [VERT_W-1:0]  o_batch_vertices,
    input  logic               o_end_of_list
);

    // no load while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result beat is pending");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_sprite_index) && $stable(o_vertex_offset))
        else $error("result beat changed while stalled");

    // first sorted sprite always opens a batch
    a_first_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_vertex_offset == '0) |-> o_starts_batch)
        else $error("first sprite does not start a batch");

    // batch size only on batch openers, never empty there
    a_batch_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_starts_batch == (o_batch_vertices != '0)))
        else $error("batch vertex count inconsistent with batch start");

    // back to loading right after the last beat of a frame
    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_end_of_list |=> o_in_ready)
        else $error("not ready for the next frame after end of list");

endmodule

bind sprite_sort_and_batch sbat_chk u_sbat_chk (.*);

/* test/tb_sprite_sort_and_batch.sv */
`timescale 1ns / 1ps

module tb_sprite_sort_and_batch;
    import sbat_pkg::*;

    localparam int CAP = MAX_SPRITES_DEF;

    typedef struct {
        logic [TEX_W-1:0]          tex;
        logic signed [DEPTH_W-1:0] depth;
        logic                      fin;
    } sprite_load_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [TEX_W-1:0]   tex;
        logic [VERT_W-1:0]  voff;
        logic               starts;
        logic [VERT_W-1:0]  bverts;
        logic               ovf;
        logic               eol;
    } sorted_beat_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [1:0]                i_cfg_wdata = 2'd0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [TEX_W-1:0]          i_texture_id = '0;
    logic signed [DEPTH_W-1:0] i_depth_key = '0;
    logic                      i_final_sprite = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [INDEX_W-1:0]        o_sprite_index;
    logic [TEX_W-1:0]          o_sprite_texture;
    logic [VERT_W-1:0]         o_vertex_offset;
    logic                      o_starts_batch;
    logic [VERT_W-1:0]         o_batch_vertices;
    logic                      o_overflowed;
    logic                      o_end_of_list;

    sprite_sort_and_batch dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_texture_id     (i_texture_id),
        .i_depth_key      (i_depth_key),
        .i_final_sprite   (i_final_sprite),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_sprite_index   (o_sprite_index),
        .o_sprite_texture (o_sprite_texture),
        .o_vertex_offset  (o_vertex_offset),
        .o_starts_batch   (o_starts_batch),
        .o_batch_vertices (o_batch_vertices),
        .o_overflowed     (o_overflowed),
        .o_end_of_list    (o_end_of_list)
    );

    // predictor state
    logic [TEX_W-1:0]          tex_mem [CAP];
    logic signed [DEPTH_W-1:0] depth_mem [CAP];
    int                        held_count = 0;
    logic                      dropped_any = 1'b0;
    t_sort_mode                cur_mode = MODE_TEX_ASC;

    sprite_load_t load_q [$];
    sorted_beat_t sorted_due [$];

    bit  in_taken = 1'b0;
    bit  calm = 1'b0;
    int  in_gap = 0;
    int  out_hold = 0;
    int  err_count = 0;
    int  loads_taken = 0;
    int  frames_sorted = 0;
    int  beats_checked = 0;
    int  overflow_frames = 0;
    int  mode_frames [4] = '{0, 0, 0, 0};
    logic [TEX_W-1:0]          last_tex = '0;
    logic signed [DEPTH_W-1:0] last_depth = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results still due", sorted_due.size());
        $display("status: fail");
        $finish;
    end

    task automatic note_mismatch(input string what);
        err_count++;
        if (err_count <= 50) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    function automatic bit ahead_of(input int a, input int b);
        case (cur_mode)
            MODE_DEPTH_DESC: return depth_mem[a] > depth_mem[b];
            MODE_DEPTH_ASC:  return depth_mem[a] < depth_mem[b];
            MODE_TEX_ASC:    return tex_mem[a] < tex_mem[b];
            default:         return 1'b0;
        endcase
    endfunction

    // load one sprite; on the final one, sort and queue the whole frame
    task automatic load_sprite(input sprite_load_t s);
        int           order_buf [CAP];
        int           i;
        int           j;
        int           cur;
        int           run;
        sorted_beat_t b;
        if (held_count < CAP) begin
            tex_mem[held_count] = s.tex;
            depth_mem[held_count] = s.depth;
            held_count++;
        end else begin
            dropped_any = 1'b1;
        end
        if (s.fin) begin
            for (i = 0; i < held_count; i++) order_buf[i] = i;
            for (i = 1; i < held_count; i++) begin
                cur = order_buf[i];
                j = i;
                while (j > 0 && ahead_of(cur, order_buf[j-1])) begin
                    order_buf[j] = order_buf[j-1];
                    j--;
                end
                order_buf[j] = cur;
            end
            for (i = 0; i < held_count; i++) begin
                b.index  = INDEX_W'(order_buf[i]);
                b.tex    = tex_mem[order_buf[i]];
                b.voff   = VERT_W'(i * VERTS_PER_SPRITE);
                b.starts = (i == 0) || (tex_mem[order_buf[i-1]] != b.tex);
                run = 0;
                if (b.starts) begin
                    j = i;
                    while (j < held_count && tex_mem[order_buf[j]] == b.tex) begin
                        run++;
                        j++;
                    end
                end
                b.bverts = VERT_W'(run * VERTS_PER_SPRITE);
                b.ovf    = dropped_any;
                b.eol    = (i == held_count - 1);
                sorted_due.push_back(b);
            end
            frames_sorted++;
            mode_frames[cur_mode]++;
            if (dropped_any) overflow_frames++;
            held_count = 0;
            dropped_any = 1'b0;
        end
    endtask

    task automatic check_beat();
        sorted_beat_t b;
        if (sorted_due.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing due, index %0d", o_sprite_index));
        end else begin
            b = sorted_due.pop_front();
            beats_checked++;
            if (o_sprite_index !== b.index)
                note_mismatch($sformatf("sprite_index %0d, want %0d", o_sprite_index, b.index));
            if (o_sprite_texture !== b.tex)
                note_mismatch($sformatf("sprite_texture %h, want %h", o_sprite_texture, b.tex));
            if (o_vertex_offset !== b.voff)
                note_mismatch($sformatf("vertex_offset %0d, want %0d", o_vertex_offset, b.voff));
            if (o_starts_batch !== b.starts)
                note_mismatch($sformatf("starts_batch %b, want %b", o_starts_batch, b.starts));
            if (o_batch_vertices !== b.bverts)
                note_mismatch($sformatf("batch_vertices %0d, want %0d",
                                        o_batch_vertices, b.bverts));
            if (o_overflowed !== b.ovf)
                note_mismatch($sformatf("overflowed %b, want %b", o_overflowed, b.ovf));
            if (o_end_of_list !== b.eol)
                note_mismatch($sformatf("end_of_list %b, want %b", o_end_of_list, b.eol));
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) check_beat();
        if (in_taken) begin
            loads_taken++;
            load_sprite('{tex: i_texture_id, depth: i_depth_key, fin: i_final_sprite});
        end
    end

    // load driver
    always @(negedge i_clk) begin
        sprite_load_t s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            i_in_valid <= 1'b1;
        end else if (in_gap > 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (load_q.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            in_gap = $urandom_range(1, 12) - 1;
            i_in_valid <= 1'b0;
        end else begin
            s = load_q.pop_front();
            i_texture_id <= s.tex;
            i_depth_key <= s.depth;
            i_final_sprite <= s.fin;
            i_in_valid <= 1'b1;
        end
    end

    // result stall driver
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_hold = $urandom_range(1, 12) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic push_load(input logic [TEX_W-1:0] tex, input int depth, input bit fin);
        load_q.push_back('{tex: tex, depth: DEPTH_W'(depth), fin: fin});
    endtask

    function automatic logic [TEX_W-1:0] rand_tex();
        case ($urandom_range(0, 3))
            0: last_tex = $urandom;
            1, 2: begin
                case ($urandom_range(0, 4))
                    0: last_tex = 32'h0000_0000;
                    1: last_tex = 32'hFFFF_FFFF;
                    2: last_tex = 32'h8000_0000;
                    3: last_tex = 32'h0000_0001;
                    default: last_tex = 32'h0000_0005;
                endcase
            end
            default: ;
        endcase
        return last_tex;
    endfunction

    function automatic logic signed [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 3))
            0, 1: last_depth = DEPTH_W'($urandom);
            2: begin
                case ($urandom_range(0, 4))
                    0: last_depth = -16'sd32768;
                    1: last_depth = 16'sd32767;
                    2: last_depth = 16'sd0;
                    3: last_depth = -16'sd1;
                    default: last_depth = 16'sd256;
                endcase
            end
            default: ;
        endcase
        return last_depth;
    endfunction

    task automatic gen_frame(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            load_q.push_back('{tex: rand_tex(), depth: rand_depth(), fin: (i == n - 1)});
        end
    endtask

    // hold the sender until every due result has been taken
    task automatic wait_idle();
        do @(posedge i_clk);
        while (load_q.size() != 0 || i_in_valid || sorted_due.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_sort_mode m);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = m;
    endtask

    initial begin
        int         random_loads;
        int         phase;
        int         nf;
        int         f;
        int         n;
        int         waited;
        t_sort_mode m;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // texture ascending out of reset, equal textures keep load order
        push_load(32'h0000_0007, 0, 1'b0);
        push_load(32'h0000_0000, 32767, 1'b0);
        push_load(32'hFFFF_FFFF, -32768, 1'b0);
        push_load(32'h0000_0007, 5, 1'b0);
        push_load(32'h0000_0000, 5, 1'b0);
        push_load(32'h0000_0007, -1, 1'b1);
        // single sprite frame
        push_load(32'hA5A5_A5A5, 16'h1234, 1'b1);

        set_mode(MODE_DEPTH_DESC);
        push_load(32'h0000_0001, 100, 1'b0);
        push_load(32'h0000_0001, -32768, 1'b0);
        push_load(32'h0000_0002, 32767, 1'b0);
        push_load(32'h0000_0002, 100, 1'b0);
        push_load(32'h0000_0001, 32767, 1'b1);

        set_mode(MODE_DEPTH_ASC);
        push_load(32'h5A5A_5A5A, 100, 1'b0);
        push_load(32'h5A5A_5A5A, -32768, 1'b0);
        push_load(32'hFFFF_FFFF, 32767, 1'b0);
        push_load(32'h0000_0000, 100, 1'b0);
        push_load(32'h0000_0000, -32768, 1'b1);

        set_mode(MODE_LOAD_ORDER);
        push_load(32'h0000_0009, 3, 1'b0);
        push_load(32'h0000_0003, -3, 1'b0);
        push_load(32'h0000_0003, 0, 1'b0);
        push_load(32'h0000_0001, 1, 1'b1);

        random_loads = 0;
        phase = 0;
        while (random_loads < 360) begin
            case (phase)
                0: m = MODE_DEPTH_ASC;
                1: m = MODE_LOAD_ORDER;
                2: m = MODE_DEPTH_DESC;
                3: m = MODE_TEX_ASC;
                default: m = t_sort_mode'(2'($urandom_range(0, 3)));
            endcase
            set_mode(m);
            if (random_loads >= 300) calm = 1'b1;
            nf = $urandom_range(2, 5);
            for (f = 0; f < nf; f++) begin
                if (phase == 0 && f == 0) n = CAP;
                else if (phase == 2 && f == 0) n = CAP + 6;
                else if (phase == 3 && f == 0) n = CAP + 1;
                else n = $urandom_range(1, 12);
                gen_frame(n);
                random_loads += n;
            end
            phase++;
        end

        waited = 0;
        while ((load_q.size() != 0 || i_in_valid || sorted_due.size() != 0) && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (sorted_due.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", sorted_due.size()));

        $display("ran %0d sprite loads in %0d frames, %0d sorted beats checked",
                 loads_taken, frames_sorted, beats_checked);
        $display("frames per mode desc/asc/texture/load-order: %0d/%0d/%0d/%0d, %0d with drops",
                 mode_frames[0], mode_frames[1], mode_frames[2], mode_frames[3],
                 overflow_frames);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
